// File: design/scd_pkg.sv
// ---------------------------------------------------------------------------
// scd_pkg
// shared types, codes and sizes of the scale command decoder queue
// ---------------------------------------------------------------------------
package scd_pkg;

   // command ring and front-to-back queue sizes
   localparam int RING_DEPTH = 8;
   localparam int RING_IDX_W = $clog2(RING_DEPTH);
   localparam int RING_CNT_W = $clog2(RING_DEPTH + 1);
   localparam int OPQ_DEPTH  = 2;
   localparam int OPQ_IDX_W  = $clog2(OPQ_DEPTH);
   localparam int OPQ_CNT_W  = $clog2(OPQ_DEPTH + 1);

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [0:0] CSR_IDX_TIMEOUT = 1'b0;
   localparam logic [15:0] TIMEOUT_RESET = 16'd5000;

   // action codes
   localparam logic [2:0] ACT_FRAME      = 3'd0;
   localparam logic [2:0] ACT_POP        = 3'd1;
   localparam logic [2:0] ACT_TICK       = 3'd2;
   localparam logic [2:0] ACT_CONNECT    = 3'd3;
   localparam logic [2:0] ACT_DISCONNECT = 3'd4;

   // frame bytes
   localparam logic [7:0] MIN_FRAME_LEN  = 8'd7;
   localparam logic [7:0] LEAD_CODE      = 8'h03;
   localparam logic [7:0] TYPE_TARE      = 8'h0F;
   localparam logic [7:0] TYPE_LED       = 8'h0A;
   localparam logic [7:0] TYPE_TIMER     = 8'h0B;
   localparam logic [7:0] TYPE_PRESSURE  = 8'hF0;
   localparam logic [7:0] TYPE_BREWSTART = 8'hF1;
   localparam logic [7:0] TYPE_BREWEND   = 8'hF2;
   localparam logic [7:0] TYPE_DISPCFG   = 8'hF3;
   localparam logic [7:0] TYPE_EXPORT    = 8'hF4;
   localparam logic [7:0] HB_ARG0        = 8'h03;
   localparam logic [7:0] HB_FILL        = 8'hFF;
   localparam logic [7:0] LED_POWEROFF   = 8'h02;
   localparam logic [7:0] LED_OFF        = 8'h00;
   localparam logic [7:0] LED_ON         = 8'h01;
   localparam logic [7:0] TIMER_START    = 8'h03;
   localparam logic [7:0] TIMER_STOP     = 8'h00;
   localparam logic [7:0] TIMER_RESET    = 8'h02;
   localparam logic [7:0] HB_AWARE_CODE  = 8'h01;

   // command kinds
   localparam logic [3:0] KIND_TARE      = 4'd0;
   localparam logic [3:0] KIND_POWEROFF  = 4'd1;
   localparam logic [3:0] KIND_LEDOFF    = 4'd2;
   localparam logic [3:0] KIND_LEDON     = 4'd3;
   localparam logic [3:0] KIND_TSTART    = 4'd4;
   localparam logic [3:0] KIND_TSTOP     = 4'd5;
   localparam logic [3:0] KIND_TRESET    = 4'd6;
   localparam logic [3:0] KIND_PRESSURE  = 4'd7;
   localparam logic [3:0] KIND_BREWSTART = 4'd8;
   localparam logic [3:0] KIND_BREWEND   = 4'd9;
   localparam logic [3:0] KIND_DISPCFG   = 4'd10;
   localparam logic [3:0] KIND_EXPORT    = 4'd11;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_HEARTBEAT,
      OP_COMMAND,
      OP_POP,
      OP_TICK,
      OP_CONNECT,
      OP_DISCONNECT
   } op_code_type;

   typedef struct packed {
      logic [7:0] arg3;
      logic [7:0] arg2;
      logic [7:0] arg1;
      logic [7:0] arg0;
      logic       hb_aware;
      logic [3:0] kind;
   } scd_entry_type;

   typedef struct packed {
      op_code_type   code;
      scd_entry_type entry;
   } scd_op_type;

   typedef struct packed {
      logic       cmd_valid;
      logic [3:0] cmd_kind;
      logic       cmd_hb_aware;
      logic [7:0] cmd_arg0;
      logic [7:0] cmd_arg1;
      logic [7:0] cmd_arg2;
      logic [7:0] cmd_arg3;
      logic       disconnect_request;
      logic       display_on;
      logic       host_mode_on;
      logic [3:0] queue_count;
      logic       link_connected;
   } scd_result_type;

   function automatic logic [RING_IDX_W-1:0] ring_next(input logic [RING_IDX_W-1:0] idx);
      logic [RING_IDX_W-1:0] nxt;
      if (idx == RING_IDX_W'(RING_DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = idx + 1'b1;
      end
      return nxt;
   endfunction

endpackage

// File: design/scd_ram.sv
// ---------------------------------------------------------------------------
// scd_ram
// generic single write port ram with registered read
// ---------------------------------------------------------------------------
module scd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/scd_front.sv
// ---------------------------------------------------------------------------
// scd_front
// accepts input items, classifies frames and holds them in a short op queue
// ---------------------------------------------------------------------------
module scd_front
   import scd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [2:0] req_action,
   input  logic [7:0] req_frame_length,
   input  logic [7:0] req_lead_byte,
   input  logic [7:0] req_type_byte,
   input  logic [7:0] req_arg_byte0,
   input  logic [7:0] req_arg_byte1,
   input  logic [7:0] req_arg_byte2,
   input  logic [7:0] req_arg_byte3,
   output logic       op_valid,
   output scd_op_type op_head,
   input  logic       op_take
);

   scd_op_type             dec_op;
   scd_op_type             opq_ff [OPQ_DEPTH];
   logic [OPQ_IDX_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [OPQ_IDX_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [OPQ_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                   wr_en;

   // frame classification
   always_comb begin
      dec_op.code           = OP_NOP;
      dec_op.entry.kind     = KIND_TARE;
      dec_op.entry.hb_aware = (req_arg_byte3 == HB_AWARE_CODE);
      dec_op.entry.arg0     = req_arg_byte0;
      dec_op.entry.arg1     = req_arg_byte1;
      dec_op.entry.arg2     = req_arg_byte2;
      dec_op.entry.arg3     = req_arg_byte3;
      unique case (req_action)
         ACT_FRAME: begin
            if (req_frame_length >= MIN_FRAME_LEN && req_lead_byte == LEAD_CODE) begin
               dec_op.code = OP_COMMAND;
               unique case (req_type_byte)
                  TYPE_TARE: begin
                     dec_op.entry.kind = KIND_TARE;
                  end
                  TYPE_LED: begin
                     if (req_arg_byte0 == HB_ARG0 && req_arg_byte1 == HB_FILL &&
                         req_arg_byte2 == HB_FILL) begin
                        dec_op.code = OP_HEARTBEAT;
                     end else if (req_arg_byte0 == LED_POWEROFF) begin
                        dec_op.entry.kind = KIND_POWEROFF;
                     end else if (req_arg_byte0 == LED_OFF) begin
                        dec_op.entry.kind = KIND_LEDOFF;
                     end else if (req_arg_byte0 == LED_ON) begin
                        dec_op.entry.kind = KIND_LEDON;
                     end else begin
                        dec_op.code = OP_NOP;
                     end
                  end
                  TYPE_TIMER: begin
                     if (req_arg_byte0 == TIMER_START) begin
                        dec_op.entry.kind = KIND_TSTART;
                     end else if (req_arg_byte0 == TIMER_STOP) begin
                        dec_op.entry.kind = KIND_TSTOP;
                     end else if (req_arg_byte0 == TIMER_RESET) begin
                        dec_op.entry.kind = KIND_TRESET;
                     end else begin
                        dec_op.code = OP_NOP;
                     end
                  end
                  TYPE_PRESSURE:  dec_op.entry.kind = KIND_PRESSURE;
                  TYPE_BREWSTART: dec_op.entry.kind = KIND_BREWSTART;
                  TYPE_BREWEND:   dec_op.entry.kind = KIND_BREWEND;
                  TYPE_DISPCFG:   dec_op.entry.kind = KIND_DISPCFG;
                  TYPE_EXPORT:    dec_op.entry.kind = KIND_EXPORT;
                  default:        dec_op.code = OP_NOP;
               endcase
            end
         end
         ACT_POP:        dec_op.code = OP_POP;
         ACT_TICK:       dec_op.code = OP_TICK;
         ACT_CONNECT:    dec_op.code = OP_CONNECT;
         ACT_DISCONNECT: dec_op.code = OP_DISCONNECT;
         default:        dec_op.code = OP_NOP;
      endcase
   end

   // op queue towards the back end
   assign full     = (cnt_ff == OPQ_CNT_W'(OPQ_DEPTH));
   assign op_valid = (cnt_ff != '0);
   assign op_head  = opq_ff[rd_ptr_ff];
   assign wr_en    = push && !full;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == OPQ_IDX_W'(OPQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (op_take) begin
         rd_ptr_in = (rd_ptr_ff == OPQ_IDX_W'(OPQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !op_take) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!wr_en && op_take) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         opq_ff[wr_ptr_ff] <= dec_op;
      end
   end

endmodule

// File: design/scd_back.sv
// ---------------------------------------------------------------------------
// scd_back
// carries out ops: command ring, watchdog, flags and the result register
// ---------------------------------------------------------------------------
module scd_back
   import scd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           op_valid,
   input  scd_op_type     op_head,
   output logic           op_take,
   input  logic [15:0]    timeout,
   input  logic           pop,
   output logic           empty,
   output scd_result_type rsp
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP,
      ST_SCAN,
      ST_RESP
   } state_type;

   state_type             state_ff, state_in;
   logic [RING_IDX_W-1:0] head_ff, head_in;
   logic [RING_IDX_W-1:0] tail_ff, tail_in;
   logic [RING_IDX_W-1:0] chk_ff, chk_in;
   logic [RING_CNT_W-1:0] count_ff, count_in;
   logic [RING_CNT_W-1:0] rem_ff, rem_in;
   logic                  connected_ff, connected_in;
   logic                  needed_ff, needed_in;
   logic [31:0]           since_ff, since_in;
   logic                  display_ff, display_in;
   logic                  app_ff, app_in;
   scd_entry_type         entry_ff, entry_in;
   logic                  valid_ff, valid_in;
   logic                  disc_ff, disc_in;
   scd_result_type        rsp_ff, rsp_in;
   logic                  rsp_full_ff, rsp_full_in;

   logic                  ram_we;
   logic [RING_IDX_W-1:0] ram_waddr;
   scd_entry_type         ram_wdata;
   logic [RING_IDX_W-1:0] ram_raddr;
   scd_entry_type         ram_rdata;
   logic [31:0]           since_inc;
   logic                  ring_has_room;
   scd_entry_type         op_entry;

   scd_ram #(
      .WIDTH ($bits(scd_entry_type)),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign since_inc     = (since_ff == 32'hFFFF_FFFF) ? since_ff : since_ff + 32'd1;
   assign ring_has_room = (count_ff < RING_CNT_W'(RING_DEPTH));
   assign op_entry      = op_head.entry;

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      chk_in       = chk_ff;
      count_in     = count_ff;
      rem_in       = rem_ff;
      connected_in = connected_ff;
      needed_in    = needed_ff;
      since_in     = since_ff;
      display_in   = display_ff;
      app_in       = app_ff;
      entry_in     = entry_ff;
      valid_in     = valid_ff;
      disc_in      = disc_ff;
      rsp_in       = rsp_ff;
      rsp_full_in  = rsp_full_ff;
      op_take      = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = tail_ff;
      ram_wdata    = entry_ff;
      ram_raddr    = head_ff;

      if (pop && rsp_full_ff) begin
         rsp_full_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (op_valid && !rsp_full_ff) begin
               op_take  = 1'b1;
               entry_in = op_entry;
               valid_in = 1'b0;
               disc_in  = 1'b0;
               state_in = ST_RESP;
               unique case (op_head.code)
                  OP_HEARTBEAT: begin
                     since_in = '0;
                  end
                  OP_COMMAND: begin
                     if (op_entry.kind == KIND_LEDOFF) begin
                        display_in = 1'b0;
                     end
                     if (op_entry.kind == KIND_LEDON) begin
                        display_in = 1'b1;
                        app_in     = 1'b1;
                     end
                     if ((op_entry.kind == KIND_TARE || op_entry.kind == KIND_LEDON) &&
                         op_entry.hb_aware) begin
                        needed_in = 1'b1;
                        since_in  = '0;
                     end
                     if ((op_entry.kind == KIND_PRESSURE || op_entry.kind == KIND_LEDON) &&
                         count_ff != '0) begin
                        // read of the head slot goes out now
                        chk_in   = head_ff;
                        rem_in   = count_ff;
                        state_in = ST_SCAN;
                     end else if (ring_has_room) begin
                        ram_we    = 1'b1;
                        ram_wdata = op_entry;
                        tail_in   = ring_next(tail_ff);
                        count_in  = count_ff + 1'b1;
                     end
                  end
                  OP_POP: begin
                     if (count_ff != '0) begin
                        state_in = ST_POP;
                     end
                  end
                  OP_TICK: begin
                     since_in = since_inc;
                     if (connected_ff && needed_ff && since_inc > 32'(timeout)) begin
                        disc_in   = 1'b1;
                        needed_in = 1'b0;
                     end
                  end
                  OP_CONNECT: begin
                     connected_in = 1'b1;
                     since_in     = '0;
                  end
                  OP_DISCONNECT: begin
                     connected_in = 1'b0;
                     app_in       = 1'b0;
                     needed_in    = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_POP: begin
            valid_in = 1'b1;
            entry_in = ram_rdata;
            head_in  = ring_next(head_ff);
            count_in = count_ff - 1'b1;
            state_in = ST_RESP;
         end
         ST_SCAN: begin
            // read data belongs to chk_ff, next slot is fetched meanwhile
            ram_raddr = ring_next(chk_ff);
            if (ram_rdata.kind == entry_ff.kind) begin
               if (entry_ff.kind == KIND_PRESSURE) begin
                  ram_we    = 1'b1;
                  ram_waddr = chk_ff;
               end
               state_in = ST_RESP;
            end else if (rem_ff == RING_CNT_W'(1)) begin
               if (ring_has_room) begin
                  ram_we   = 1'b1;
                  tail_in  = ring_next(tail_ff);
                  count_in = count_ff + 1'b1;
               end
               state_in = ST_RESP;
            end else begin
               chk_in = ring_next(chk_ff);
               rem_in = rem_ff - 1'b1;
            end
         end
         ST_RESP: begin
            rsp_in.cmd_valid          = valid_ff;
            rsp_in.cmd_kind           = valid_ff ? entry_ff.kind : '0;
            rsp_in.cmd_hb_aware       = valid_ff && entry_ff.hb_aware;
            rsp_in.cmd_arg0           = valid_ff ? entry_ff.arg0 : '0;
            rsp_in.cmd_arg1           = valid_ff ? entry_ff.arg1 : '0;
            rsp_in.cmd_arg2           = valid_ff ? entry_ff.arg2 : '0;
            rsp_in.cmd_arg3           = valid_ff ? entry_ff.arg3 : '0;
            rsp_in.disconnect_request = disc_ff;
            rsp_in.display_on         = display_ff;
            rsp_in.host_mode_on       = app_ff;
            rsp_in.queue_count        = 4'(count_ff);
            rsp_in.link_connected     = connected_ff;
            rsp_full_in               = 1'b1;
            state_in                  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         connected_ff <= 1'b0;
         needed_ff    <= 1'b0;
         since_ff     <= '0;
         display_ff   <= 1'b0;
         app_ff       <= 1'b0;
         rsp_full_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         connected_ff <= connected_in;
         needed_ff    <= needed_in;
         since_ff     <= since_in;
         display_ff   <= display_in;
         app_ff       <= app_in;
         rsp_full_ff  <= rsp_full_in;
      end
      chk_ff   <= chk_in;
      rem_ff   <= rem_in;
      entry_ff <= entry_in;
      valid_ff <= valid_in;
      disc_ff  <= disc_in;
      rsp_ff   <= rsp_in;
   end

   assign empty = !rsp_full_ff;
   assign rsp   = rsp_ff;

endmodule

// File: design/scale_command_decoder_queue_core.sv
// ---------------------------------------------------------------------------
// scale_command_decoder_queue_core
// sequence: a taken item goes to the response state, which registers its
// result; a pop first reads the head entry in the pop state, and a pressure
// or led-on command with entries queued first scans them in the scan state
// flow: the back end takes no new item until the result of the last one is
// registered and popped; the sequencer and the single result register see to it
// reset: synchronous; state, status flags, ring and queue pointers and
// counts clear; ring contents stay and only queued entries are ever read
// ---------------------------------------------------------------------------
module scale_command_decoder_queue_core
   import scd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // input channel
   input  logic                  push,
   output logic                  full,
   input  logic [2:0]            req_action,
   input  logic [7:0]            req_frame_length,
   input  logic [7:0]            req_lead_byte,
   input  logic [7:0]            req_type_byte,
   input  logic [7:0]            req_arg_byte0,
   input  logic [7:0]            req_arg_byte1,
   input  logic [7:0]            req_arg_byte2,
   input  logic [7:0]            req_arg_byte3,
   // result channel
   output logic                  empty,
   input  logic                  pop,
   output logic                  rsp_cmd_valid,
   output logic [3:0]            rsp_cmd_kind,
   output logic                  rsp_cmd_hb_aware,
   output logic [7:0]            rsp_cmd_arg0,
   output logic [7:0]            rsp_cmd_arg1,
   output logic [7:0]            rsp_cmd_arg2,
   output logic [7:0]            rsp_cmd_arg3,
   output logic                  rsp_disconnect_request,
   output logic                  rsp_display_on,
   output logic                  rsp_host_mode_on,
   output logic [3:0]            rsp_queue_count,
   output logic                  rsp_link_connected,
   // configuration port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic [15:0]    timeout_ff, timeout_in;
   logic           csr_sel_timeout;
   logic           op_valid;
   logic           op_take;
   scd_op_type     op_head;
   scd_result_type rsp;

   // configuration register
   assign pready          = 1'b1;
   assign csr_sel_timeout = (paddr[CSR_ADDR_W-1:2] == CSR_IDX_TIMEOUT);
   assign prdata          = csr_sel_timeout ? CSR_DATA_W'(timeout_ff) : '0;

   always_comb begin
      timeout_in = timeout_ff;
      if (psel && penable && pwrite && pready && csr_sel_timeout) begin
         timeout_in = pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else begin
         timeout_ff <= timeout_in;
      end
   end

   scd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_action       (req_action),
      .req_frame_length (req_frame_length),
      .req_lead_byte    (req_lead_byte),
      .req_type_byte    (req_type_byte),
      .req_arg_byte0    (req_arg_byte0),
      .req_arg_byte1    (req_arg_byte1),
      .req_arg_byte2    (req_arg_byte2),
      .req_arg_byte3    (req_arg_byte3),
      .op_valid         (op_valid),
      .op_head          (op_head),
      .op_take          (op_take)
   );

   scd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .op_valid (op_valid),
      .op_head  (op_head),
      .op_take  (op_take),
      .timeout  (timeout_ff),
      .pop      (pop),
      .empty    (empty),
      .rsp      (rsp)
   );

   assign rsp_cmd_valid          = rsp.cmd_valid;
   assign rsp_cmd_kind           = rsp.cmd_kind;
   assign rsp_cmd_hb_aware       = rsp.cmd_hb_aware;
   assign rsp_cmd_arg0           = rsp.cmd_arg0;
   assign rsp_cmd_arg1           = rsp.cmd_arg1;
   assign rsp_cmd_arg2           = rsp.cmd_arg2;
   assign rsp_cmd_arg3           = rsp.cmd_arg3;
   assign rsp_disconnect_request = rsp.disconnect_request;
   assign rsp_display_on         = rsp.display_on;
   assign rsp_host_mode_on       = rsp.host_mode_on;
   assign rsp_queue_count        = rsp.queue_count;
   assign rsp_link_connected     = rsp.link_connected;

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the scale command decoder queue: a directed opening
// and random command traffic go through the push side while the pop side
// drains status transfers. The heartbeat timeout is set between phases over
// the config port. Every status transfer is compared field by field with a
// local model of the decoder, the ring and the watchdog.
// ---------------------------------------------------------------------------
module tb_top;
   import scd_pkg::*;

   localparam logic [2:0] ACT_SPARE_LO = 3'd5;
   localparam logic [2:0] ACT_SPARE_HI = 3'd7;
   localparam int SPARE_REG_IDX = 1;
   localparam logic [CSR_ADDR_W-1:0] TIMEOUT_ADDR = CSR_ADDR_W'(4 * CSR_IDX_TIMEOUT);
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR   = CSR_ADDR_W'(4 * SPARE_REG_IDX);
   localparam int NUM_PHASES   = 6;
   localparam int PHASE_ITEMS  = 205;
   localparam int LONG_HOLD    = 300;
   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 20;
   localparam int MAX_REPORTS  = 40;

   typedef struct {
      logic [2:0] action;
      logic [7:0] flen;
      logic [7:0] lead;
      logic [7:0] ftype;
      logic [7:0] arg0;
      logic [7:0] arg1;
      logic [7:0] arg2;
      logic [7:0] arg3;
   } cmd_item_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  push = 1'b0;
   logic                  full;
   logic [2:0]            req_action = ACT_FRAME;
   logic [7:0]            req_frame_length = '0;
   logic [7:0]            req_lead_byte = '0;
   logic [7:0]            req_type_byte = '0;
   logic [7:0]            req_arg_byte0 = '0;
   logic [7:0]            req_arg_byte1 = '0;
   logic [7:0]            req_arg_byte2 = '0;
   logic [7:0]            req_arg_byte3 = '0;
   logic                  empty;
   logic                  pop = 1'b0;
   logic                  rsp_cmd_valid;
   logic [3:0]            rsp_cmd_kind;
   logic                  rsp_cmd_hb_aware;
   logic [7:0]            rsp_cmd_arg0;
   logic [7:0]            rsp_cmd_arg1;
   logic [7:0]            rsp_cmd_arg2;
   logic [7:0]            rsp_cmd_arg3;
   logic                  rsp_disconnect_request;
   logic                  rsp_display_on;
   logic                  rsp_host_mode_on;
   logic [3:0]            rsp_queue_count;
   logic                  rsp_link_connected;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   scale_command_decoder_queue_core u_dut (.*);

   // model of ring, flags and watchdog
   scd_entry_type ring_mem [RING_DEPTH];
   int            ring_rd = 0;
   int            ring_wr = 0;
   int            ring_used = 0;
   logic          link_up = 1'b0;
   logic          hb_needed = 1'b0;
   logic          display_flag = 1'b0;
   logic          host_mode = 1'b0;
   logic [31:0]   since_hb = '0;
   logic [15:0]   hb_limit = TIMEOUT_RESET;

   cmd_item_type   items_to_send [$];
   scd_result_type status_due [$];
   cmd_item_type   on_wire;

   int idle_pct = 0;
   logic hold_long_req = 1'b0;
   logic hold_long_done = 1'b0;
   int send_gap = 0;
   int hold_cnt = 0;
   int stall_cycles = 0;

   int items_accepted = 0;
   int results_seen = 0;
   int cmds_popped = 0;
   int disconnects = 0;
   int pressure_merges = 0;
   int full_drops = 0;
   int csr_writes = 0;
   int mismatch_count = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("[%0t] mismatch: %s", $time, what);
      end
   endtask

   function automatic void store_command(input scd_entry_type e);
      int k;
      int slot;
      if (e.kind == KIND_PRESSURE || e.kind == KIND_LEDON) begin
         for (k = 0; k < ring_used; k++) begin
            slot = (ring_rd + k) % RING_DEPTH;
            if (ring_mem[slot].kind == e.kind) begin
               if (e.kind == KIND_PRESSURE) begin
                  ring_mem[slot] = e;
                  pressure_merges++;
               end
               return;
            end
         end
      end
      if (ring_used >= RING_DEPTH) begin
         full_drops++;
         return;
      end
      ring_mem[ring_wr] = e;
      ring_wr = (ring_wr + 1) % RING_DEPTH;
      ring_used++;
   endfunction

   function automatic void decode_frame(input cmd_item_type it);
      scd_entry_type e;
      logic aware;
      logic keep;
      aware = (it.arg3 == HB_AWARE_CODE);
      keep = 1'b1;
      e = '0;
      if (it.flen < MIN_FRAME_LEN || it.lead != LEAD_CODE) begin
         return;
      end
      case (it.ftype)
         TYPE_TARE: begin
            e.kind = KIND_TARE;
            if (aware) begin
               hb_needed = 1'b1;
               since_hb = '0;
            end
         end
         TYPE_LED: begin
            if (it.arg0 == HB_ARG0 && it.arg1 == HB_FILL && it.arg2 == HB_FILL) begin
               since_hb = '0;
               keep = 1'b0;
            end else begin
               case (it.arg0)
                  LED_POWEROFF: e.kind = KIND_POWEROFF;
                  LED_OFF: begin
                     e.kind = KIND_LEDOFF;
                     display_flag = 1'b0;
                  end
                  LED_ON: begin
                     e.kind = KIND_LEDON;
                     display_flag = 1'b1;
                     host_mode = 1'b1;
                     if (aware) begin
                        hb_needed = 1'b1;
                        since_hb = '0;
                     end
                  end
                  default: keep = 1'b0;
               endcase
            end
         end
         TYPE_TIMER: begin
            case (it.arg0)
               TIMER_START: e.kind = KIND_TSTART;
               TIMER_STOP:  e.kind = KIND_TSTOP;
               TIMER_RESET: e.kind = KIND_TRESET;
               default:     keep = 1'b0;
            endcase
         end
         TYPE_PRESSURE:  e.kind = KIND_PRESSURE;
         TYPE_BREWSTART: e.kind = KIND_BREWSTART;
         TYPE_BREWEND:   e.kind = KIND_BREWEND;
         TYPE_DISPCFG:   e.kind = KIND_DISPCFG;
         TYPE_EXPORT:    e.kind = KIND_EXPORT;
         default:        keep = 1'b0;
      endcase
      if (keep) begin
         e.hb_aware = aware;
         e.arg0 = it.arg0;
         e.arg1 = it.arg1;
         e.arg2 = it.arg2;
         e.arg3 = it.arg3;
         store_command(e);
      end
   endfunction

   function automatic scd_result_type predict_status(input cmd_item_type it);
      scd_result_type r;
      scd_entry_type taken;
      r = '0;
      case (it.action)
         ACT_FRAME: decode_frame(it);
         ACT_POP: begin
            if (ring_used != 0) begin
               taken = ring_mem[ring_rd];
               ring_rd = (ring_rd + 1) % RING_DEPTH;
               ring_used--;
               r.cmd_valid = 1'b1;
               r.cmd_kind = taken.kind;
               r.cmd_hb_aware = taken.hb_aware;
               r.cmd_arg0 = taken.arg0;
               r.cmd_arg1 = taken.arg1;
               r.cmd_arg2 = taken.arg2;
               r.cmd_arg3 = taken.arg3;
            end
         end
         ACT_TICK: begin
            if (since_hb != '1) begin
               since_hb = since_hb + 1'b1;
            end
            if (link_up && hb_needed && since_hb > 32'(hb_limit)) begin
               r.disconnect_request = 1'b1;
               hb_needed = 1'b0;
            end
         end
         ACT_CONNECT: begin
            link_up = 1'b1;
            since_hb = '0;
         end
         ACT_DISCONNECT: begin
            link_up = 1'b0;
            host_mode = 1'b0;
            hb_needed = 1'b0;
         end
         default: ;
      endcase
      r.display_on = display_flag;
      r.host_mode_on = host_mode;
      r.queue_count = 4'(ring_used);
      r.link_connected = link_up;
      return r;
   endfunction

   function automatic cmd_item_type plain_item(input logic [2:0] action);
      cmd_item_type it;
      it.action = action;
      it.flen = 8'($urandom);
      it.lead = 8'($urandom);
      it.ftype = 8'($urandom);
      it.arg0 = 8'($urandom);
      it.arg1 = 8'($urandom);
      it.arg2 = 8'($urandom);
      it.arg3 = 8'($urandom);
      return it;
   endfunction

   function automatic cmd_item_type frame_item(input logic [7:0] flen, input logic [7:0] lead,
                                               input logic [7:0] ftype, input logic [7:0] a0,
                                               input logic [7:0] a1, input logic [7:0] a2,
                                               input logic [7:0] a3);
      cmd_item_type it;
      it.action = ACT_FRAME;
      it.flen = flen;
      it.lead = lead;
      it.ftype = ftype;
      it.arg0 = a0;
      it.arg1 = a1;
      it.arg2 = a2;
      it.arg3 = a3;
      return it;
   endfunction

   function automatic cmd_item_type random_item(input int pop_pct);
      cmd_item_type it;
      int pick;
      it = plain_item(ACT_FRAME);
      it.flen = 8'($urandom_range(MIN_FRAME_LEN, 255));
      if ($urandom_range(0, 7) == 0) begin
         it.flen = MIN_FRAME_LEN;
      end
      it.lead = LEAD_CODE;
      if ($urandom_range(0, 1) == 1) begin
         it.arg3 = HB_AWARE_CODE;
      end
      pick = $urandom_range(0, 99);
      if (pick < pop_pct) begin
         it.action = ACT_POP;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            case ($urandom_range(0, 10))
               0: it.ftype = TYPE_TARE;
               1, 2: begin
                  it.ftype = TYPE_LED;
                  case ($urandom_range(0, 2))
                     0: it.arg0 = LED_POWEROFF;
                     1: it.arg0 = LED_OFF;
                     default: it.arg0 = LED_ON;
                  endcase
               end
               3: begin
                  it.ftype = TYPE_TIMER;
                  case ($urandom_range(0, 2))
                     0: it.arg0 = TIMER_START;
                     1: it.arg0 = TIMER_STOP;
                     default: it.arg0 = TIMER_RESET;
                  endcase
               end
               4, 5: it.ftype = TYPE_PRESSURE;
               6: it.ftype = TYPE_BREWSTART;
               7: it.ftype = TYPE_BREWEND;
               8: it.ftype = TYPE_DISPCFG;
               9: it.ftype = TYPE_EXPORT;
               default: begin
                  it.ftype = TYPE_LED;
                  it.arg0 = HB_ARG0;
                  it.arg1 = HB_FILL;
                  it.arg2 = HB_FILL;
               end
            endcase
         end else if (pick < 72) begin
            it.action = ACT_TICK;
         end else if (pick < 78) begin
            it.action = ACT_CONNECT;
         end else if (pick < 81) begin
            it.action = ACT_DISCONNECT;
         end else if (pick < 93) begin
            // malformed frames, random type byte kept unless replaced
            case ($urandom_range(0, 3))
               0: it.flen = 8'($urandom_range(0, MIN_FRAME_LEN - 1));
               1: it.lead = LEAD_CODE ^ 8'($urandom_range(1, 255));
               2: ;
               default: it.ftype = ($urandom_range(0, 1) == 1) ? TYPE_LED : TYPE_TIMER;
            endcase
         end else begin
            it.action = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
         end
      end
      return it;
   endfunction

   task automatic queue_directed();
      items_to_send.push_back(plain_item(ACT_POP));
      // short frame and wrong lead
      items_to_send.push_back(frame_item(MIN_FRAME_LEN - 8'd1, LEAD_CODE, TYPE_TARE,
                                         8'h00, 8'h00, 8'h00, HB_AWARE_CODE));
      items_to_send.push_back(frame_item(MIN_FRAME_LEN, LEAD_CODE ^ 8'h01, TYPE_TARE,
                                         8'h00, 8'h00, 8'h00, 8'h00));
      items_to_send.push_back(frame_item(8'hFF, LEAD_CODE, TYPE_TARE,
                                         8'hFF, 8'hFF, 8'hFF, HB_AWARE_CODE));
      items_to_send.push_back(frame_item(MIN_FRAME_LEN, LEAD_CODE, TYPE_LED,
                                         LED_POWEROFF, 8'h00, 8'hFF, 8'h00));
      items_to_send.push_back(frame_item(MIN_FRAME_LEN, LEAD_CODE, TYPE_LED,
                                         LED_OFF, 8'hFF, 8'h00, 8'hFF));
      items_to_send.push_back(frame_item(MIN_FRAME_LEN, LEAD_CODE, TYPE_LED,
                                         LED_ON, 8'h00, 8'h00, HB_AWARE_CODE));
      // duplicate led-on
      items_to_send.push_back(frame_item(MIN_FRAME_LEN, LEAD_CODE, TYPE_LED,
                                         LED_ON, 8'h55, 8'hAA, 8'hFF));
      items_to_send.push_back(frame_item(MIN_FRAME_LEN, LEAD_CODE, TYPE_LED,
                                         8'h80, 8'h00, 8'h00, 8'h00));
      items_to_send.push_back(frame_item(MIN_FRAME_LEN, LEAD_CODE, TYPE_LED,
                                         HB_ARG0, HB_FILL, HB_FILL, 8'h00));
      items_to_send.push_back(frame_item(MIN_FRAME_LEN, LEAD_CODE, TYPE_TIMER,
                                         TIMER_START, 8'h00, 8'h00, 8'h00));
      items_to_send.push_back(frame_item(MIN_FRAME_LEN, LEAD_CODE, TYPE_TIMER,
                                         TIMER_STOP, 8'h00, 8'h00, 8'h00));
      items_to_send.push_back(frame_item(MIN_FRAME_LEN, LEAD_CODE, TYPE_TIMER,
                                         TIMER_RESET, 8'h00, 8'h00, 8'h00));
      items_to_send.push_back(frame_item(MIN_FRAME_LEN, LEAD_CODE, TYPE_TIMER,
                                         8'hFF, 8'h00, 8'h00, 8'h00));
      // pressure, then a second one that lands on the same entry
      items_to_send.push_back(frame_item(MIN_FRAME_LEN, LEAD_CODE, TYPE_PRESSURE,
                                         8'hFF, 8'hFF, 8'h00, 8'h00));
      items_to_send.push_back(frame_item(MIN_FRAME_LEN, LEAD_CODE, TYPE_PRESSURE,
                                         8'h00, 8'h00, 8'hFF, 8'hFF));
      // ring is full from here on
      items_to_send.push_back(frame_item(MIN_FRAME_LEN, LEAD_CODE, TYPE_BREWSTART,
                                         8'h01, 8'h02, 8'h03, 8'h04));
      items_to_send.push_back(frame_item(MIN_FRAME_LEN, LEAD_CODE, TYPE_BREWEND,
                                         8'h01, 8'h02, 8'h03, 8'h04));
      items_to_send.push_back(frame_item(MIN_FRAME_LEN, LEAD_CODE, TYPE_DISPCFG,
                                         8'h01, 8'h02, 8'h03, 8'h04));
      items_to_send.push_back(frame_item(MIN_FRAME_LEN, LEAD_CODE, TYPE_EXPORT,
                                         8'h01, 8'h02, 8'h03, 8'h04));
      items_to_send.push_back(frame_item(MIN_FRAME_LEN, LEAD_CODE, 8'h00,
                                         8'h00, 8'h00, 8'h00, 8'h00));
      items_to_send.push_back(plain_item(ACT_CONNECT));
      items_to_send.push_back(plain_item(ACT_SPARE_HI));
      items_to_send.push_back(plain_item(ACT_TICK));
      items_to_send.push_back(plain_item(ACT_DISCONNECT));
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (items_to_send.size() != 0 || push || status_due.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (addr == TIMEOUT_ADDR) begin
         hb_limit = data[15:0];
      end
      csr_writes++;
   endtask

   task automatic csr_check();
      @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b0;
      penable <= 1'b0;
      paddr <= TIMEOUT_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[15:0] !== hb_limit) begin
         report_mismatch($sformatf("timeout readback %0h, want %0h", prdata[15:0], hb_limit));
      end
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic check_field(input string label, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("status %0d %s: got %0h, want %0h",
                                   results_seen, label, got, want));
      end
   endtask

   task automatic compare_status(input scd_result_type got, input scd_result_type want);
      check_field("cmd_valid", 8'(got.cmd_valid), 8'(want.cmd_valid));
      check_field("cmd_kind", 8'(got.cmd_kind), 8'(want.cmd_kind));
      check_field("cmd_hb_aware", 8'(got.cmd_hb_aware), 8'(want.cmd_hb_aware));
      check_field("cmd_arg0", got.cmd_arg0, want.cmd_arg0);
      check_field("cmd_arg1", got.cmd_arg1, want.cmd_arg1);
      check_field("cmd_arg2", got.cmd_arg2, want.cmd_arg2);
      check_field("cmd_arg3", got.cmd_arg3, want.cmd_arg3);
      check_field("disconnect_request", 8'(got.disconnect_request),
                  8'(want.disconnect_request));
      check_field("display_on", 8'(got.display_on), 8'(want.display_on));
      check_field("host_mode_on", 8'(got.host_mode_on), 8'(want.host_mode_on));
      check_field("queue_count", 8'(got.queue_count), 8'(want.queue_count));
      check_field("link_connected", 8'(got.link_connected), 8'(want.link_connected));
   endtask

   // command driver
   always @(posedge clock) begin : drv_proc
      logic nxt_push;
      nxt_push = push;
      if (!reset) begin
         if (push && !full) begin
            status_due.push_back(predict_status(on_wire));
            items_accepted++;
            nxt_push = 1'b0;
         end
         if (!nxt_push) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (items_to_send.size() != 0) begin
               if ($urandom_range(0, 99) < idle_pct) begin
                  send_gap = $urandom_range(1, 19) - 1;
               end else begin
                  on_wire = items_to_send.pop_front();
                  req_action <= on_wire.action;
                  req_frame_length <= on_wire.flen;
                  req_lead_byte <= on_wire.lead;
                  req_type_byte <= on_wire.ftype;
                  req_arg_byte0 <= on_wire.arg0;
                  req_arg_byte1 <= on_wire.arg1;
                  req_arg_byte2 <= on_wire.arg2;
                  req_arg_byte3 <= on_wire.arg3;
                  nxt_push = 1'b1;
               end
            end
         end
         push <= nxt_push;
      end
   end

   // status monitor
   always @(posedge clock) begin : mon_proc
      scd_result_type got;
      scd_result_type want;
      if (!reset) begin
         if (pop && !empty) begin
            got = {rsp_cmd_valid, rsp_cmd_kind, rsp_cmd_hb_aware, rsp_cmd_arg0,
                   rsp_cmd_arg1, rsp_cmd_arg2, rsp_cmd_arg3, rsp_disconnect_request,
                   rsp_display_on, rsp_host_mode_on, rsp_queue_count, rsp_link_connected};
            results_seen++;
            if (got.cmd_valid === 1'b1) begin
               cmds_popped++;
            end
            if (got.disconnect_request === 1'b1) begin
               disconnects++;
            end
            if (status_due.size() == 0) begin
               report_mismatch($sformatf("status transfer %0d with nothing outstanding",
                                         results_seen));
            end else begin
               want = status_due.pop_front();
               compare_status(got, want);
            end
         end
         if (hold_long_req && !hold_long_done) begin
            hold_cnt = LONG_HOLD;
            hold_long_done = 1'b1;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            pop <= 1'b0;
         end else if ($urandom_range(0, 99) < idle_pct) begin
            hold_cnt = $urandom_range(1, 19) - 1;
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // no-progress watchdog
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || (psel && penable && pready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("no transfer for %0d cycles", stall_cycles);
         $display("Regression FAIL");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : stim_proc
      logic [15:0] phase_limit [NUM_PHASES];
      int ph;
      int n;
      int pop_pct;
      phase_limit = '{16'd0, 16'd1, 16'hFFFF, 16'd7, 16'd25, 16'd3};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      idle_pct = $urandom_range(0, 12);
      queue_directed();
      wait_drained();
      for (ph = 0; ph < NUM_PHASES; ph++) begin
         csr_write(TIMEOUT_ADDR, {16'($urandom), phase_limit[ph]});
         if (ph == 4) begin
            csr_write(SPARE_ADDR, $urandom);
         end
         csr_check();
         @(negedge clock);
         idle_pct = (ph == NUM_PHASES - 1) ? 0 : $urandom_range(0, 12);
         hold_long_req = (ph == 3);
         pop_pct = $urandom_range(20, 45);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            items_to_send.push_back(random_item(pop_pct));
         end
         wait_drained();
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d commands and status transfers, %0d entries popped, %0d watchdog trips",
               items_accepted, cmds_popped, disconnects);
      $display("pressure overwrites %0d, commands lost to a full ring %0d, register writes %0d",
               pressure_merges, full_drops, csr_writes);
      if (mismatch_count == 0 && status_due.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
